/* hw/rtl/c_subset_tokenizer_unit_defines.svh */
// assertion macros shared by the tokenizer rtl
// needs clk_i and rst_ni in the module that uses them
`ifndef C_SUBSET_TOKENIZER_UNIT_DEFINES_SVH
`define C_SUBSET_TOKENIZER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define CST_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cst_pkg.sv */
// types, constants and character helpers for the c subset tokenizer
// no dependencies
`default_nettype none

package cst_pkg;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NAME = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_HALT = 2'd3;

  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_NAME   = 5'd15;
  localparam logic [4:0] KIND_LIT    = 5'd16;
  localparam logic [4:0] KIND_PUNCT0 = 5'd17;

  localparam int KW_NUM    = 14;
  localparam int KW_MAXLEN = 8;

  localparam logic [8*KW_MAXLEN-1:0] KW_STR [KW_NUM] = '{
    "int", "while", "switch", "break", "for", "continue", "else",
    "do", "if", "void", "char", "float", "double", "return"
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd3, 4'd5, 4'd6, 4'd5, 4'd3, 4'd8, 4'd4,
    4'd2, 4'd2, 4'd4, 4'd4, 4'd5, 4'd6, 4'd6
  };

  localparam logic [3:0] PUNCT_NONE = 4'd9;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SPACE,
    CLS_PUNCT,
    CLS_OTHER
  } byte_cls_e;

  typedef enum logic [2:0] {
    EM_KW,
    EM_LIT,
    EM_CHAR,
    EM_PUNCT,
    EM_END
  } emit_sel_e;

  typedef struct packed {
    logic      take;
    logic      extend;
    logic      start;
    logic      emit;
    emit_sel_e emit_sel;
    logic      load_rd;
    logic      next_rd;
    logic      mode_idle;
    logic      mode_halt;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       in_ext;
    logic       in_fin;
    logic       kw_hit;
    byte_cls_e  cls;
    logic       fin;
    logic       out_free;
    logic       run_end;
  } dp_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident_head(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == 8'h5F);
  endfunction

  function automatic logic [3:0] punct_idx(input logic [7:0] c);
    logic [3:0] r;
    r = PUNCT_NONE;
    unique case (c)
      8'h7B:   r = 4'd0;
      8'h7D:   r = 4'd1;
      8'h28:   r = 4'd2;
      8'h29:   r = 4'd3;
      8'h3B:   r = 4'd4;
      8'h3D:   r = 4'd5;
      8'h2B:   r = 4'd6;
      8'h2D:   r = 4'd7;
      8'h2C:   r = 4'd8;
      default: r = PUNCT_NONE;
    endcase
    return r;
  endfunction

  function automatic byte_cls_e byte_cls(input logic [7:0] c);
    byte_cls_e r;
    if (is_ident_head(c)) begin
      r = CLS_LETTER;
    end else if (is_digit(c)) begin
      r = CLS_DIGIT;
    end else if ((c == 8'h20) || (c == 8'h0A)) begin
      r = CLS_SPACE;
    end else if (punct_idx(c) != PUNCT_NONE) begin
      r = CLS_PUNCT;
    end else begin
      r = CLS_OTHER;
    end
    return r;
  endfunction

  // character at position p of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] p);
    logic [8*KW_MAXLEN-1:0] w;
    w = KW_STR[k] << (8 * (KW_MAXLEN - int'(KW_LEN[k])));
    return w[8*KW_MAXLEN-1-8*p -: 8];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cst_ifs.sv */
// valid/ready word channels for source bytes and tokens
// no dependencies
`default_nettype none

interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       final_byte;

  modport source (output valid, src_byte, final_byte, input ready);
  modport sink   (input valid, src_byte, final_byte, output ready);
endinterface

interface cst_out_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  token_kind;
  logic signed [31:0] literal_value;
  logic        [7:0]  name_char;
  logic               run_last;
  logic               name_cut;

  modport source (output valid, token_kind, literal_value, name_char, run_last, name_cut,
                  input ready);
  modport sink   (input valid, token_kind, literal_value, name_char, run_last, name_cut,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/cst_ctrl.sv */
// tokenizer sequencer: accepts bytes and steps flush, name, action and end phases
// depends on cst_pkg
`default_nettype none

module cst_ctrl
  import cst_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FLUSH = 3'd1;
  localparam logic [2:0] ST_NAME  = 3'd2;
  localparam logic [2:0] ST_ACT   = 3'd3;
  localparam logic [2:0] ST_END   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       final_q, final_d;
  logic [2:0] after_flush;

  assign after_flush = final_q ? ST_END : ST_ACT;
  assign in_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    final_d = final_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.mode == MODE_HALT) begin
            cmd_o.mode_idle = stat_i.in_fin;
          end else if (stat_i.in_ext) begin
            cmd_o.extend = 1'b1;
            if (stat_i.in_fin) begin
              state_d = ST_FLUSH;
              final_d = 1'b1;
            end
          end else begin
            state_d = ST_FLUSH;
            final_d = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (stat_i.mode == MODE_NAME) begin
          if (stat_i.kw_hit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EM_KW;
            if (stat_i.out_free) begin
              cmd_o.mode_idle = 1'b1;
              state_d         = after_flush;
            end
          end else begin
            cmd_o.load_rd = 1'b1;
            state_d       = ST_NAME;
          end
        end else if (stat_i.mode == MODE_NUM) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_LIT;
          if (stat_i.out_free) begin
            cmd_o.mode_idle = 1'b1;
            state_d         = after_flush;
          end
        end else begin
          state_d = after_flush;
        end
      end
      ST_NAME: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = EM_CHAR;
        if (stat_i.out_free) begin
          if (stat_i.run_end) begin
            cmd_o.mode_idle = 1'b1;
            state_d         = after_flush;
          end else begin
            cmd_o.next_rd = 1'b1;
          end
        end
      end
      ST_ACT: begin
        unique case (stat_i.cls)
          CLS_LETTER, CLS_DIGIT: begin
            cmd_o.start = 1'b1;
            state_d     = stat_i.fin ? ST_FLUSH : ST_IDLE;
            final_d     = 1'b1;
          end
          CLS_SPACE: begin
            state_d = stat_i.fin ? ST_END : ST_IDLE;
          end
          CLS_PUNCT: begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EM_PUNCT;
            if (stat_i.out_free) begin
              state_d = stat_i.fin ? ST_END : ST_IDLE;
            end
          end
          CLS_OTHER: begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EM_END;
            if (stat_i.out_free) begin
              cmd_o.mode_halt = !stat_i.fin;
              state_d         = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_END: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = EM_END;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cst_dpath.sv */
// tokenizer datapath: name store, keyword match, literal accumulator, output register
// depends on cst_pkg, cst_ifs and the assertion macro header
`default_nettype none
`include "c_subset_tokenizer_unit_defines.svh"

module cst_dpath
  import cst_pkg::*;
#(
  parameter int MAX_NAME = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     [7:0] src_byte_i,
  input  wire logic     final_byte_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_stat_t      stat_o,
  cst_out_if.source     out_o
);

  localparam int AW = $clog2(MAX_NAME);
  localparam int CW = $clog2(MAX_NAME + 1);

  logic [7:0]        name_mem [MAX_NAME];
  logic [1:0]        mode_q, mode_d;
  logic [CW-1:0]     count_q;
  logic              cut_q;
  logic [KW_NUM-1:0] mask_q;
  logic [31:0]       sum_q;
  logic [AW-1:0]     idx_q;
  logic [7:0]        rd_q;
  logic [7:0]        byte_q;
  logic              fin_q;

  logic              out_valid_q;
  logic [4:0]        kind_q;
  logic [31:0]       lit_q;
  logic [7:0]        char_q;
  logic              last_q;
  logic              cutout_q;

  byte_cls_e         in_cls, cls_q;
  logic              room;
  logic              name_ext;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              pos_ok;
  logic [KW_NUM-1:0] mask_ext, mask_start;
  logic              kw_hit;
  logic [4:0]        kw_kind;
  logic              run_end;
  logic              out_free;
  logic              load_out;
  logic [4:0]        kind_d;
  logic [31:0]       lit_d;
  logic [7:0]        char_d;
  logic              last_d;
  logic              cutout_d;

  assign in_cls   = byte_cls(src_byte_i);
  assign cls_q    = byte_cls(byte_q);
  assign room     = (count_q < CW'(MAX_NAME));
  assign name_ext = cmd_i.extend && (mode_q == MODE_NAME);
  assign run_end  = ((CW'(idx_q) + CW'(1)) == count_q);
  assign out_free = !out_valid_q || out_o.ready;
  assign load_out = cmd_i.emit && out_free;

  assign wr_en   = (name_ext && room) || (cmd_i.start && (cls_q == CLS_LETTER));
  assign wr_addr = cmd_i.start ? AW'(0) : count_q[AW-1:0];
  assign wr_data = cmd_i.start ? byte_q : src_byte_i;
  assign rd_en   = cmd_i.load_rd || cmd_i.next_rd;
  assign rd_addr = cmd_i.load_rd ? AW'(0) : AW'(idx_q + 1'b1);

  // running keyword candidates, narrowed as each character is stored
  assign pos_ok = (count_q < CW'(KW_MAXLEN));
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = KIND_END;
    for (int k = 0; k < KW_NUM; k++) begin
      mask_ext[k]   = mask_q[k] && pos_ok && (CW'(KW_LEN[k]) > count_q) &&
                      (kw_char(k, count_q[2:0]) == src_byte_i);
      mask_start[k] = (kw_char(k, 3'd0) == byte_q);
      if (mask_q[k] && (CW'(KW_LEN[k]) == count_q)) begin
        kw_hit  = !cut_q;
        kw_kind = 5'(k + 1);
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    if (cmd_i.mode_halt) begin
      mode_d = MODE_HALT;
    end else if (cmd_i.mode_idle) begin
      mode_d = MODE_IDLE;
    end else if (cmd_i.start) begin
      mode_d = (cls_q == CLS_LETTER) ? MODE_NAME : MODE_NUM;
    end
  end

  always_comb begin
    kind_d   = KIND_END;
    lit_d    = '0;
    char_d   = '0;
    last_d   = 1'b1;
    cutout_d = 1'b0;
    unique case (cmd_i.emit_sel)
      EM_KW:    kind_d = kw_kind;
      EM_LIT: begin
        kind_d = KIND_LIT;
        lit_d  = sum_q;
      end
      EM_CHAR: begin
        kind_d   = KIND_NAME;
        char_d   = rd_q;
        last_d   = run_end;
        cutout_d = cut_q;
      end
      EM_PUNCT: kind_d = KIND_PUNCT0 + {1'b0, punct_idx(byte_q)};
      EM_END:   kind_d = KIND_END;
      default:  kind_d = KIND_END;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      name_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= name_mem[rd_addr];
    end
    if (cmd_i.take) begin
      byte_q <= src_byte_i;
      fin_q  <= final_byte_i;
    end
    if (load_out) begin
      kind_q   <= kind_d;
      lit_q    <= lit_d;
      char_q   <= char_d;
      last_q   <= last_d;
      cutout_q <= cutout_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      count_q     <= '0;
      cut_q       <= 1'b0;
      mask_q      <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      if (name_ext) begin
        if (room) begin
          count_q <= count_q + CW'(1);
          mask_q  <= mask_ext;
        end else begin
          cut_q <= 1'b1;
        end
      end else if (cmd_i.start && (cls_q == CLS_LETTER)) begin
        count_q <= CW'(1);
        cut_q   <= 1'b0;
        mask_q  <= mask_start;
      end
      if (cmd_i.extend && (mode_q == MODE_NUM)) begin
        sum_q <= {sum_q[28:0], 3'b000} + {sum_q[30:0], 1'b0} + {28'd0, src_byte_i[3:0]};
      end else if (cmd_i.start && (cls_q == CLS_DIGIT)) begin
        sum_q <= {28'd0, byte_q[3:0]};
      end
      if (cmd_i.load_rd) begin
        idx_q <= '0;
      end else if (cmd_i.next_rd) begin
        idx_q <= AW'(idx_q + 1'b1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.in_ext   = ((mode_q == MODE_NAME) &&
                            ((in_cls == CLS_LETTER) || (in_cls == CLS_DIGIT))) ||
                           ((mode_q == MODE_NUM) && (in_cls == CLS_DIGIT));
  assign stat_o.in_fin   = final_byte_i;
  assign stat_o.kw_hit   = kw_hit;
  assign stat_o.cls      = cls_q;
  assign stat_o.fin      = fin_q;
  assign stat_o.out_free = out_free;
  assign stat_o.run_end  = run_end;

  assign out_o.valid         = out_valid_q;
  assign out_o.token_kind    = kind_q;
  assign out_o.literal_value = $signed(lit_q);
  assign out_o.name_char     = char_q;
  assign out_o.run_last      = last_q;
  assign out_o.name_cut      = cutout_q;

  `CST_ASSERT_ALWAYS(a_count_range, count_q <= CW'(MAX_NAME), "name count beyond store")
  `CST_ASSERT_IMP(a_char_in_run, cmd_i.emit && (cmd_i.emit_sel == EM_CHAR),
    CW'(idx_q) < count_q, "name read past stored characters")
  `CST_ASSERT_IMP(a_cut_only_name, out_valid_q && (kind_q != KIND_NAME), !cutout_q,
    "cut flag on a non-name word")
  `CST_ASSERT_IMP(a_halt_silent, mode_q == MODE_HALT, !cmd_i.emit && !wr_en,
    "activity while halted")

endmodule

`default_nettype wire

/* hw/rtl/c_subset_tokenizer_unit.sv */
// c subset tokenizer: source bytes in, tokens out
// input channel src_byte/final_byte, output channel token words; valid/ready on both.
// a byte that extends the pending name or literal is taken while the sequencer stays
// idle, and the next byte can follow at once. a byte that ends a token passes a flush
// step emitting a keyword or literal, or reading the name store to emit a plain name
// one character per word, then an action step, and an end word step on a final byte.
// a name run is limited by MAX_NAME characters; longer names are cut and flagged.
// the result sits in an output register, so a new byte is taken while the last word
// waits; while the receiver stalls the sequencer holds in the emitting step.
// after an unknown byte an end word is sent and bytes are dropped up to a final byte.
// reset (rst_ni low, asynchronous) empties the output register and returns to idle
// between tokens; the name store is not cleared and needs no clearing pass.
// depends on cst_pkg, cst_ifs, cst_ctrl, cst_dpath
`default_nettype none

module c_subset_tokenizer_unit
  import cst_pkg::*;
#(
  parameter int MAX_NAME = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cst_in_if.sink     in_i,
  cst_out_if.source  out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cst_dpath #(
    .MAX_NAME (MAX_NAME)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_byte_i   (in_i.src_byte),
    .final_byte_i (in_i.final_byte),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_c_subset_tokenizer_unit.sv */
// token prediction and scoreboard, then the top-level testbench for c_subset_tokenizer_unit
// drives directed and random c subset streams, checks every token word against the predictor
// depends on cst_pkg, cst_ifs and the tokenizer rtl
`default_nettype none

package tokenizer_tb_pkg;
  import cst_pkg::*;

  localparam int NAME_MAX = 32;

  typedef enum logic [4:0] {
    TK_END = 5'd0,
    TK_INT, TK_WHILE, TK_SWITCH, TK_BREAK, TK_FOR, TK_CONTINUE, TK_ELSE,
    TK_DO, TK_IF, TK_VOID, TK_CHAR, TK_FLOAT, TK_DOUBLE, TK_RETURN,
    TK_NAME, TK_LIT,
    TK_LBRACE, TK_RBRACE, TK_LPAREN, TK_RPAREN, TK_SEMI, TK_ASSIGN,
    TK_PLUS, TK_MINUS, TK_COMMA
  } token_kind_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] lit;
    logic [7:0]  ch;
    logic        last;
    logic        cut;
  } token_word_t;

  function automatic string keyword_text(input token_kind_e k);
    case (k)
      TK_INT:      return "int";
      TK_WHILE:    return "while";
      TK_SWITCH:   return "switch";
      TK_BREAK:    return "break";
      TK_FOR:      return "for";
      TK_CONTINUE: return "continue";
      TK_ELSE:     return "else";
      TK_DO:       return "do";
      TK_IF:       return "if";
      TK_VOID:     return "void";
      TK_CHAR:     return "char";
      TK_FLOAT:    return "float";
      TK_DOUBLE:   return "double";
      TK_RETURN:   return "return";
      default:     return "";
    endcase
  endfunction

  function automatic logic [7:0] punct_text(input token_kind_e k);
    case (k)
      TK_LBRACE: return "{";
      TK_RBRACE: return "}";
      TK_LPAREN: return "(";
      TK_RPAREN: return ")";
      TK_SEMI:   return ";";
      TK_ASSIGN: return "=";
      TK_PLUS:   return "+";
      TK_MINUS:  return "-";
      TK_COMMA:  return ",";
      default:   return 8'h00;
    endcase
  endfunction

  class token_scoreboard;
    token_word_t token_q[$];
    int unsigned fails;
    logic [1:0]  mode;
    logic [7:0]  name_buf [NAME_MAX];
    int unsigned name_len;
    logic [31:0] lit_acc;
    logic        cut;

    function new();
      fails    = 0;
      mode     = MODE_IDLE;
      name_len = 0;
      lit_acc  = '0;
      cut      = 1'b0;
    endfunction

    function int unsigned pending();
      return token_q.size();
    endfunction

    function bit letter_ch(input logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function bit digit_ch(input logic [7:0] c);
      return c inside {["0":"9"]};
    endfunction

    function void push_word(input token_kind_e kind, input logic [31:0] lit,
                            input logic [7:0] ch, input logic last, input logic flag);
      token_word_t w;
      w = '{kind: kind, lit: lit, ch: ch, last: last, cut: flag};
      token_q.push_back(w);
    endfunction

    function void flush_token();
      string word;
      word = "";
      if (mode == MODE_NAME) begin
        if (!cut) begin
          for (int i = 0; i < name_len; i++) word = $sformatf("%s%c", word, name_buf[i]);
          for (int k = TK_INT; k <= TK_RETURN; k++) begin
            if (keyword_text(token_kind_e'(k)) == word) begin
              push_word(token_kind_e'(k), '0, '0, 1'b1, 1'b0);
              mode = MODE_IDLE;
              return;
            end
          end
        end
        for (int i = 0; i < name_len; i++)
          push_word(TK_NAME, '0, name_buf[i], i == name_len - 1, cut);
      end else if (mode == MODE_NUM) begin
        push_word(TK_LIT, lit_acc, '0, 1'b1, 1'b0);
      end
      mode = MODE_IDLE;
    endfunction

    // returns 1 when the byte was not dropped by a halted stream
    function bit note_byte(input logic [7:0] c, input logic fin);
      token_kind_e pk;
      pk = TK_END;
      if (mode == MODE_HALT) begin
        if (fin) mode = MODE_IDLE;
        return 1'b0;
      end
      if (mode == MODE_NAME && (letter_ch(c) || digit_ch(c))) begin
        if (name_len < NAME_MAX) begin
          name_buf[name_len] = c;
          name_len++;
        end else begin
          cut = 1'b1;
        end
      end else if (mode == MODE_NUM && digit_ch(c)) begin
        lit_acc = lit_acc * 32'd10 + 32'(c - "0");
      end else begin
        flush_token();
        if (letter_ch(c)) begin
          mode        = MODE_NAME;
          name_buf[0] = c;
          name_len    = 1;
          cut         = 1'b0;
        end else if (digit_ch(c)) begin
          mode    = MODE_NUM;
          lit_acc = 32'(c - "0");
        end else if (c == " " || c == 8'h0A) begin
          mode = MODE_IDLE;
        end else begin
          for (int k = TK_LBRACE; k <= TK_COMMA; k++)
            if (punct_text(token_kind_e'(k)) == c) pk = token_kind_e'(k);
          if (pk != TK_END) begin
            push_word(pk, '0, '0, 1'b1, 1'b0);
          end else begin
            // unknown byte: end word, then drop bytes up to the final one
            push_word(TK_END, '0, '0, 1'b1, 1'b0);
            mode = fin ? MODE_IDLE : MODE_HALT;
            return 1'b1;
          end
        end
      end
      if (fin) begin
        flush_token();
        push_word(TK_END, '0, '0, 1'b1, 1'b0);
        mode = MODE_IDLE;
      end
      return 1'b1;
    endfunction

    function void compare_field(input string field, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", field, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_word(input token_word_t got);
      token_word_t exp_w;
      if (token_q.size() == 0) begin
        $error("token word with none expected: kind %0d", got.kind);
        fails++;
        return;
      end
      exp_w = token_q.pop_front();
      compare_field("token_kind", 32'(exp_w.kind), 32'(got.kind));
      compare_field("literal_value", exp_w.lit, got.lit);
      compare_field("name_char", 32'(exp_w.ch), 32'(got.ch));
      compare_field("run_last", 32'(exp_w.last), 32'(got.last));
      compare_field("name_cut", 32'(exp_w.cut), 32'(got.cut));
    endfunction
  endclass

endpackage

module tb_c_subset_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;
  import tokenizer_tb_pkg::*;

  localparam int          CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_BYTES  = 60;

  logic clk_i = 1'b0;
  logic rst_ni;

  cst_in_if  in_if ();
  cst_out_if out_if ();

  c_subset_tokenizer_unit #(
    .MAX_NAME(NAME_MAX)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  token_scoreboard sb;
  bit              idle_on;
  bit              stall_req;
  int unsigned     stall_left;
  int unsigned     used_bytes;
  int unsigned     cycles;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[c_subset_tokenizer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_word('{kind: out_if.token_kind, lit: out_if.literal_value,
                      ch: out_if.name_char, last: out_if.run_last, cut: out_if.name_cut});
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (idle_on && $urandom_range(99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.src_byte   <= b;
    in_if.final_byte <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    used_bytes += sb.note_byte(b, fin);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [7:0] name_char(input bit lead);
    int unsigned r;
    r = lead ? $urandom_range(52) : $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  task automatic send_stream(input int unsigned n_tok);
    logic [7:0]  src_q[$];
    string       kw;
    int unsigned len;
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(11))
        0, 1, 2: begin
          kw = keyword_text(token_kind_e'($urandom_range(TK_RETURN, TK_INT)));
          for (int i = 0; i < kw.len(); i++) src_q.push_back(kw[i]);
        end
        3, 4, 5: begin
          len = ($urandom_range(7) == 0) ? $urandom_range(40, 30) : $urandom_range(8, 1);
          src_q.push_back(name_char(1'b1));
          for (int i = 1; i < len; i++) src_q.push_back(name_char(1'b0));
        end
        6, 7: begin
          len = $urandom_range(12, 1);
          for (int i = 0; i < len; i++) src_q.push_back(8'("0" + $urandom_range(9)));
        end
        8, 9, 10: src_q.push_back(punct_text(token_kind_e'($urandom_range(TK_COMMA, TK_LBRACE))));
        default: src_q.push_back(8'($urandom_range(255)));
      endcase
      if ($urandom_range(9) < 6) src_q.push_back($urandom_range(1) ? " " : 8'h0A);
    end
    foreach (src_q[i]) send_byte(src_q[i], i == src_q.size() - 1);
  endtask

  initial begin
    int unsigned streams;
    sb               = new();
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.src_byte   = '0;
    in_if.final_byte = 1'b0;
    idle_on          = 1'b1;
    stall_req        = 1'b0;
    used_bytes       = 0;
    cycles           = 0;
    streams          = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_text("{}();=+-,");
    send_text("if 4294967301");
    send_text("_Zz09abcdefghijklmnopqrstuvwxyz_Q");
    send_byte("x", 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte("q", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text("do\n");
    wait_drained();

    used_bytes = 0;
    while ((used_bytes < RAND_BYTES) || (streams < 3)) begin
      streams++;
      idle_on = (streams != 1);
      if (streams == 2) stall_req = 1'b1;
      if (streams == 3) wait_drained();
      send_stream($urandom_range(6, 2));
    end

    wait_drained();
    if (sb.fails == 0) begin
      $display("[c_subset_tokenizer_unit] OK");
    end else begin
      $display("[c_subset_tokenizer_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cst_pkg.sv
hw/rtl/cst_ifs.sv
hw/rtl/cst_ctrl.sv
hw/rtl/cst_dpath.sv
hw/rtl/c_subset_tokenizer_unit.sv
tb/sv/tb_c_subset_tokenizer_unit.sv
